>>> hw/rtl/fcf_pkg.sv
package fcf_pkg;

  // filter structure
  localparam int TAPS      = 5;
  localparam int NUM_COEFS = 30;
  localparam int SECTIONS  = 12;
  localparam int IDX_W     = 5;
  localparam int DIGIT_W   = 4;

  // coefficient tap codes inside one design
  localparam logic [2:0] TAP_B0 = 3'd0;
  localparam logic [2:0] TAP_B1 = 3'd1;
  localparam logic [2:0] TAP_B2 = 3'd2;
  localparam logic [2:0] TAP_A1 = 3'd3;
  localparam logic [2:0] TAP_A2 = 3'd4;

  // request kinds carried in tuser
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // control from the sequencer to the digit-serial mac
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic load;   // load operand and coefficient shift registers
    logic step;   // consume one operand digit
    logic neg;    // subtract this product
    logic last;   // current digit is the signed top digit
  } mac_ctrl_t;

  // sections whose input is the raw sample rather than the previous section output
  function automatic logic takes_sample(input logic [3:0] sec);
    return (sec == 4'd0) || (sec == 4'd2) || (sec == 4'd6) || (sec == 4'd10);
  endfunction

endpackage

>>> hw/rtl/fcf_mac.sv
module fcf_mac import fcf_pkg::*; #(
  parameter int SW = 24,
  parameter int CW = 32
) (
  input  logic          clk_i,
  input  mac_ctrl_t     ctrl_i,
  input  logic [SW-1:0] operand_i,
  input  logic [CW-1:0] coef_i,
  output logic [SW-1:0] y_o
);

  localparam int ND = (SW + DIGIT_W - 1) / DIGIT_W;
  localparam int DW = ND * DIGIT_W;
  localparam int PW = CW + DW;
  localparam int AW = PW + 3;
  localparam int F  = CW - 4;
  localparam logic [AW-1:0] ROUND = AW'(1) << (F - 1);

  logic signed [AW-1:0] acc_q, acc_d;
  logic        [PW-1:0] creg_q, creg_d;
  logic        [DW-1:0] sreg_q, sreg_d;

  logic signed [DIGIT_W:0]   dig;
  logic signed [PW+DIGIT_W:0] pp;
  logic signed [AW-1:0]      pp_ext;

  // one digit of the operand times the shifted coefficient
  always_comb begin
    dig    = ctrl_i.last ? $signed({sreg_q[DIGIT_W-1], sreg_q[DIGIT_W-1:0]})
                         : $signed({1'b0, sreg_q[DIGIT_W-1:0]});
    pp     = $signed(creg_q) * dig;
    pp_ext = AW'(pp);
    acc_d  = acc_q;
    creg_d = creg_q;
    sreg_d = sreg_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end
    if (ctrl_i.load) begin
      creg_d = PW'($signed(coef_i));
      sreg_d = DW'($signed(operand_i));
    end else if (ctrl_i.step) begin
      acc_d  = ctrl_i.neg ? acc_q - pp_ext : acc_q + pp_ext;
      creg_d = creg_q << DIGIT_W;
      sreg_d = sreg_q >> DIGIT_W;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    creg_q <= creg_d;
    sreg_q <= sreg_d;
  end

  // round to nearest and saturate to the sample range
  logic [AW-1:0]      rnd;
  logic [AW-F-SW:0]   top;
  logic               ovf;
  always_comb begin
    rnd = acc_q + ROUND;
    top = rnd[AW-1:F+SW-1];
    ovf = !((&top) || !(|top));
    if (ovf) begin
      y_o = rnd[AW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      y_o = rnd[F+SW-1:F];
    end
  end

endmodule

>>> hw/rtl/four_band_crossover_filterbank.sv
// channel  dir  tdata (low bit up)                        tuser (low bit up)
// s_axis   in   sample, coef_index, coef_value, zero pad   op, channel
// m_axis   out  band_low, band_mid_low, band_mid_high,     -
//               band_high, zero pad
//
// a sample runs through 12 sections of five taps each, with ND =
// ceil(SAMPLE_WIDTH/4) operand digits per tap, on the single 4-bit
// digit-serial mac shared by all sixty products
// a coefficient write gives no result
// reset clears coefficients and marks all section history as zero
// the input stalls while a sample is in flight; a finished result waits in
// the output register and only the end of the next sample waits for it
module four_band_crossover_filterbank import fcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 32,
  parameter int CHANNELS     = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  // sample, coef_index, coef_value, zero pad
  input  logic [((SAMPLE_WIDTH+IDX_W+COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // op, channel
  input  logic [1:0]                                       s_axis_tuser,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  // band_low, band_mid_low, band_mid_high, band_high, zero pad
  output logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]              m_axis_tdata
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COEF_WIDTH;
  localparam int OUT_W = ((4 * SW + 7) / 8) * 8;
  localparam int DEPTH = CHANNELS * SECTIONS;
  localparam int AD_W  = $clog2(DEPTH);
  localparam int ND    = (SW + DIGIT_W - 1) / DIGIT_W;
  localparam int ND_W  = $clog2(ND);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LOAD, S_DIGIT, S_WRITE, S_DONE
  } state_e;

  state_e           state_q;
  logic             ch_q;
  logic [3:0]       sec_q;
  logic [2:0]       term_q;
  logic [ND_W-1:0]  dig_q;
  logic [SW-1:0]    x_q, y_q;
  logic [SW-1:0]    band_q [4];
  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  // input fields
  logic             in_op, in_ch;
  logic [SW-1:0]    in_sample;
  logic [IDX_W-1:0] in_idx;
  logic [CW-1:0]    in_coef;
  logic             accept;

  assign in_op     = s_axis_tuser[0];
  assign in_ch     = s_axis_tuser[1];
  assign in_sample = s_axis_tdata[SW-1:0];
  assign in_idx    = s_axis_tdata[SW+IDX_W-1:SW];
  assign in_coef   = s_axis_tdata[SW+IDX_W+CW-1:SW+IDX_W];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // coefficient store
  logic [CW-1:0] coef_q [NUM_COEFS];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) coef_q[i] <= '0;
    end else if (accept && in_op == OP_COEF && in_idx < IDX_W'(NUM_COEFS)) begin
      coef_q[in_idx] <= in_coef;
    end
  end

  logic [IDX_W-1:0] coef_idx;
  logic [CW-1:0]    coef_sel;
  assign coef_idx = IDX_W'({2'b0, sec_q[3:1]} * IDX_W'(TAPS)) + IDX_W'(term_q);
  assign coef_sel = coef_q[coef_idx];

  // section history memory: x1, x2, y1, y2 from the low bits up
  logic [AD_W-1:0] hist_addr;
  logic [4*SW-1:0] hist_mem [DEPTH];
  logic [DEPTH-1:0] hist_vld_q;
  logic [4*SW-1:0] hist_rd_q, hist;
  logic            hist_rd_vld_q;
  logic [SW-1:0]   sec_in, y_new, operand;

  assign hist_addr = AD_W'(ch_q) * AD_W'(SECTIONS) + AD_W'(sec_q);
  assign hist      = hist_rd_vld_q ? hist_rd_q : '0;
  assign sec_in    = takes_sample(sec_q) ? x_q : y_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      hist_rd_q <= hist_mem[hist_addr];
    end
    if (state_q == S_WRITE) begin
      hist_mem[hist_addr] <= {hist[3*SW-1:2*SW], y_new, hist[SW-1:0], sec_in};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q    <= '0;
      hist_rd_vld_q <= 1'b0;
    end else begin
      if (state_q == S_READ) hist_rd_vld_q <= hist_vld_q[hist_addr];
      if (state_q == S_WRITE) hist_vld_q[hist_addr] <= 1'b1;
    end
  end

  // operand for the current tap
  always_comb begin
    case (term_q)
      TAP_B0:  operand = sec_in;
      TAP_B1:  operand = hist[SW-1:0];
      TAP_B2:  operand = hist[2*SW-1:SW];
      TAP_A1:  operand = hist[3*SW-1:2*SW];
      default: operand = hist[4*SW-1:3*SW];
    endcase
  end

  // mac control
  mac_ctrl_t mac_ctrl;
  always_comb begin
    mac_ctrl.clear = (state_q == S_READ);
    mac_ctrl.load  = (state_q == S_LOAD);
    mac_ctrl.step  = (state_q == S_DIGIT);
    mac_ctrl.neg   = (term_q == TAP_A1) || (term_q == TAP_A2);
    mac_ctrl.last  = (dig_q == ND_W'(ND - 1));
  end

  fcf_mac #(.SW(SW), .CW(CW)) u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (mac_ctrl),
    .operand_i (operand),
    .coef_i    (coef_sel),
    .y_o       (y_new)
  );

  // sequencer over sections, taps and digits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ch_q      <= 1'b0;
      sec_q     <= '0;
      term_q    <= '0;
      dig_q     <= '0;
      x_q       <= '0;
      y_q       <= '0;
      for (int i = 0; i < 4; i++) band_q[i] <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != S_DONE) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept && in_op == OP_FILTER) begin
            ch_q    <= (CHANNELS > 1) ? in_ch : 1'b0;
            x_q     <= in_sample;
            sec_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          term_q  <= TAP_B0;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          dig_q   <= '0;
          state_q <= S_DIGIT;
        end
        S_DIGIT: begin
          if (dig_q == ND_W'(ND - 1)) begin
            if (term_q == TAP_A2) begin
              state_q <= S_WRITE;
            end else begin
              term_q  <= term_q + 3'd1;
              state_q <= S_LOAD;
            end
          end else begin
            dig_q <= dig_q + ND_W'(1);
          end
        end
        S_WRITE: begin
          y_q <= y_new;
          case (sec_q)
            4'd1:    band_q[0] <= y_new;
            4'd5:    band_q[1] <= y_new;
            4'd9:    band_q[2] <= y_new;
            4'd11:   band_q[3] <= y_new;
            default: ;
          endcase
          if (sec_q == 4'(SECTIONS - 1)) begin
            state_q <= S_DONE;
          end else begin
            sec_q   <= sec_q + 4'd1;
            state_q <= S_READ;
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OUT_W'({band_q[3], band_q[2], band_q[1], band_q[0]});
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks on the sequencer
  a_write_after_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |-> term_q == TAP_A2)
    else $error("section written before its last tap");
  a_done_last_section: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> sec_q == 4'(SECTIONS - 1))
    else $error("result before all sections ran");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside completion");
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIGIT |-> dig_q <= ND_W'(ND - 1))
    else $error("digit counter out of range");

endmodule

>>> tb/sv/tb_four_band_crossover_filterbank.sv
module tb_four_band_crossover_filterbank;
  import fcf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = 24;
  localparam int CW = 32;
  localparam int FRAC = CW - 4;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [SW-1:0] low, mid_low, mid_high, high;
  } bands_t;

  // crossover predictor and store of expected band results
  class band_scoreboard;
    longint coef[NUM_COEFS];
    longint hist[2][SECTIONS][4];
    bands_t band_q[$];
    int errors;

    function longint run_biquad(int ch, int sec, longint x);
      int d;
      longint acc, y;
      d = (sec / 2) * TAPS;
      acc = coef[d + TAP_B0] * x + coef[d + TAP_B1] * hist[ch][sec][0]
          + coef[d + TAP_B2] * hist[ch][sec][1] - coef[d + TAP_A1] * hist[ch][sec][2]
          - coef[d + TAP_A2] * hist[ch][sec][3];
      y = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (y > 64'sd8388607) y = 64'sd8388607;
      if (y < -64'sd8388608) y = -64'sd8388608;
      hist[ch][sec][1] = hist[ch][sec][0];
      hist[ch][sec][0] = x;
      hist[ch][sec][3] = hist[ch][sec][2];
      hist[ch][sec][2] = y;
      return y;
    endfunction

    // note an accepted request and queue the bands it produces
    function void note_request(logic op, logic ch, logic signed [SW-1:0] smp,
                               logic [IDX_W-1:0] idx, logic signed [CW-1:0] val);
      bands_t b;
      longint x, t;
      int c;
      if (op == OP_COEF) begin
        if (idx < NUM_COEFS) coef[idx] = longint'(val);
        return;
      end
      c = ch;
      x = longint'(smp);
      b.low = SW'(run_biquad(c, 1, run_biquad(c, 0, x)));
      t = run_biquad(c, 3, run_biquad(c, 2, x));
      b.mid_low = SW'(run_biquad(c, 5, run_biquad(c, 4, t)));
      t = run_biquad(c, 7, run_biquad(c, 6, x));
      b.mid_high = SW'(run_biquad(c, 9, run_biquad(c, 8, t)));
      b.high = SW'(run_biquad(c, 11, run_biquad(c, 10, x)));
      band_q.push_back(b);
    endfunction

    function void check_result(logic [95:0] d);
      bands_t e;
      if (band_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, d);
        errors++;
        return;
      end
      e = band_q.pop_front();
      if (d[23:0] !== e.low) begin
        $display("%0t: band_low expected %h actual %h", $time, e.low, d[23:0]);
        errors++;
      end
      if (d[47:24] !== e.mid_low) begin
        $display("%0t: band_mid_low expected %h actual %h", $time, e.mid_low, d[47:24]);
        errors++;
      end
      if (d[71:48] !== e.mid_high) begin
        $display("%0t: band_mid_high expected %h actual %h", $time, e.mid_high, d[71:48]);
        errors++;
      end
      if (d[95:72] !== e.high) begin
        $display("%0t: band_high expected %h actual %h", $time, e.high, d[95:72]);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic [95:0] m_axis_tdata;

  band_scoreboard sb;
  bit no_idle;
  bit hold_req;
  longint cycles;

  four_band_crossover_filterbank dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("four_band_crossover_filterbank test failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 11);
  endfunction

  // one request on the input side
  task automatic send_request(logic op, logic ch, logic [SW-1:0] smp,
                              logic [IDX_W-1:0] idx, logic [CW-1:0] val);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= {ch, op};
    s_axis_tdata <= {3'b000, val, idx, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, ch, smp, idx, val);
  endtask

  task automatic write_coef(int idx, logic [CW-1:0] val);
    send_request(OP_COEF, 1'($urandom_range(0, 1)), SW'($urandom), idx[IDX_W-1:0], val);
  endtask

  task automatic filter_sample(logic ch, logic [SW-1:0] smp);
    send_request(OP_FILTER, ch, smp, IDX_W'($urandom), $urandom);
  endtask

  function automatic logic [CW-1:0] rand_coef();
    logic [CW-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = 32'd1 << FRAC;
      2: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: begin
        v = $urandom >> $urandom_range(4, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [SW-1:0] rand_sample();
    logic [SW-1:0] v;
    if ($urandom_range(0, 1)) return SW'($urandom);
    v = SW'($urandom >> $urandom_range(8, 31));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // result side with random stalls and one long hold-off
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = hold_req ? 3000 : draw_gap();
      hold_req = 1'b0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  // stimulus
  initial begin
    sb = new();
    cycles = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all coefficients zero gives silent bands
    filter_sample(1'b0, 24'h7fffff);
    filter_sample(1'b1, 24'h800000);
    // unity b0 everywhere passes the sample through
    for (int d = 0; d < 6; d++) write_coef(d * TAPS + TAP_B0, 32'd1 << FRAC);
    filter_sample(1'b0, 24'h7fffff);
    filter_sample(1'b0, 24'h800000);
    filter_sample(1'b1, 24'h000000);
    // writes past the store are ignored
    write_coef(30, 32'h7fffffff);
    write_coef(31, 32'h80000000);
    filter_sample(1'b1, 24'h123456);
    // extreme coefficients saturate both ways
    write_coef(TAP_B0, 32'h7fffffff);
    write_coef(TAPS + TAP_A1, 32'h80000000);
    write_coef(2 * TAPS + TAP_B1, 32'hffffffff);
    filter_sample(1'b0, 24'h7fffff);
    filter_sample(1'b0, 24'h800000);
    filter_sample(1'b1, 24'h7fffff);
    filter_sample(1'b1, 24'h800000);

    for (int i = 0; i < 1800; i++) begin
      if (i == 300) hold_req = 1'b1;
      no_idle = (i >= 600 && i < 800);
      if (i == 1000) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.band_q.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 3) == 0)
        write_coef($urandom_range(0, 31), rand_coef());
      else
        filter_sample(1'($urandom_range(0, 1)), rand_sample());
    end
    s_axis_tvalid <= 1'b0;

    while (sb.band_q.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (sb.errors == 0 && sb.band_q.size() == 0)
      $display("four_band_crossover_filterbank test passed");
    else
      $display("four_band_crossover_filterbank test failed");
    $finish;
  end
endmodule
